// ----- rtl/dsmr_pkg.sv -----
// ----------------------------------------------------------------------------
// DSMR telegram checker package
// Shared types, character codes, status codes and the CRC-16/ARC byte update.
// ----------------------------------------------------------------------------
package dsmr_pkg;

    localparam logic [7:0]  CHAR_START    = 8'h2F;
    localparam logic [7:0]  CHAR_BANG     = 8'h21;
    localparam logic [7:0]  CHAR_LF       = 8'h0A;
    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [15:0] CRC_INIT      = 16'h0000;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [2:0]  HEX_DIGITS    = 3'd4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_START   = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_CRC_ERROR  = 2'd3
    } status_t;

    typedef struct packed {
        logic       pre_verified;
        logic       end_of_buffer;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic [15:0] telegram_length;
        status_t     status;
    } result_t;

    // Reflected CRC-16 update over one byte, unrolled over its eight bits.
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Bit 4 set means the byte is a valid hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0_0000;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// ----- rtl/dsmr_in_stage.sv -----
// ----------------------------------------------------------------------------
// DSMR input register
// Holds one received byte until the frame logic consumes it.
// ----------------------------------------------------------------------------
module dsmr_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dsmr_pkg::in_item_t s_item,
    input  logic              consume,
    output logic              item_valid,
    output dsmr_pkg::in_item_t item
);
    import dsmr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    // The register may refill in the same cycle that it is consumed.
    assign s_tready   = !valid_reg || consume;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/dsmr_frame.sv -----
// ----------------------------------------------------------------------------
// DSMR frame tracker
// Keeps the per-telegram state and decides the result for each byte.
// ----------------------------------------------------------------------------
module dsmr_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dsmr_pkg::in_item_t item,
    output logic               res_valid,
    output dsmr_pkg::result_t  res
);
    import dsmr_pkg::*;

    logic [15:0] pos_reg,     pos_next;
    logic        bang_reg,    bang_next;
    logic [15:0] crc_reg,     crc_next;
    logic [15:0] snap_reg,    snap_next;
    logic [15:0] hex_reg,     hex_next;
    logic [2:0]  cnt_reg,     cnt_next;
    logic        inval_reg,   inval_next;
    logic        cr_reg,      cr_next;
    logic        discard_reg, discard_next;

    logic [7:0]  b;
    logic [4:0]  nib;
    logic [15:0] pos_inc;
    logic        check_ok;
    logic        clear_all;

    always_comb
    begin
        b            = item.data_byte;
        nib          = hex_nibble(b);
        pos_next     = pos_reg;
        bang_next    = bang_reg;
        crc_next     = crc_reg;
        snap_next    = snap_reg;
        hex_next     = hex_reg;
        cnt_next     = cnt_reg;
        inval_next   = inval_reg;
        cr_next      = cr_reg;
        discard_next = discard_reg;
        pos_inc      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;
        check_ok     = 1'b0;
        clear_all    = 1'b0;
        res_valid    = 1'b0;
        res          = '{computed_crc: 16'h0000, received_crc: 16'h0000,
                         telegram_length: 16'h0000, status: ST_OK};

        if (fire)
        begin
            if (discard_reg)
            begin
                clear_all = item.end_of_buffer;
            end
            else if (pos_reg == 16'h0000 && b != CHAR_START)
            begin
                res_valid    = 1'b1;
                res.status   = ST_NO_START;
                discard_next = 1'b1;
                clear_all    = item.end_of_buffer;
            end
            else
            begin
                crc_next = crc16_arc_byte(crc_reg, b);
                if (pos_reg != 16'h0000 && b == CHAR_BANG)
                begin
                    bang_next  = 1'b1;
                    snap_next  = crc_next;
                    hex_next   = 16'h0000;
                    cnt_next   = 3'd0;
                    inval_next = 1'b0;
                end
                else if (bang_reg && cnt_reg < HEX_DIGITS)
                begin
                    hex_next   = {hex_reg[11:0], nib[3:0]};
                    cnt_next   = cnt_reg + 3'd1;
                    inval_next = inval_reg || !nib[4];
                end
                check_ok = (cnt_next == HEX_DIGITS) && !inval_next
                           && (hex_next == snap_next);

                if (bang_next && b == CHAR_LF && cr_reg)
                begin
                    res_valid           = 1'b1;
                    res.status          = check_ok ? ST_OK : ST_CRC_ERROR;
                    res.telegram_length = pos_reg;
                    res.received_crc    = hex_next;
                    res.computed_crc    = snap_next;
                    discard_next        = 1'b1;
                    clear_all           = item.end_of_buffer;
                end
                else
                begin
                    cr_next  = (b == CHAR_CR);
                    pos_next = pos_inc;
                    if (item.end_of_buffer)
                    begin
                        res_valid = 1'b1;
                        clear_all = 1'b1;
                        if (!item.pre_verified)
                        begin
                            res.status = ST_INCOMPLETE;
                        end
                        else
                        begin
                            res.telegram_length = pos_inc;
                            if (bang_next)
                            begin
                                res.status       = check_ok ? ST_OK : ST_CRC_ERROR;
                                res.received_crc = hex_next;
                                res.computed_crc = snap_next;
                            end
                        end
                    end
                end
            end
        end

        // Every buffer end returns the tracker to its reset state.
        if (clear_all)
        begin
            pos_next     = 16'h0000;
            bang_next    = 1'b0;
            crc_next     = CRC_INIT;
            snap_next    = 16'h0000;
            hex_next     = 16'h0000;
            cnt_next     = 3'd0;
            inval_next   = 1'b0;
            cr_next      = 1'b0;
            discard_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 16'h0000;
            bang_reg    <= 1'b0;
            crc_reg     <= CRC_INIT;
            snap_reg    <= 16'h0000;
            hex_reg     <= 16'h0000;
            cnt_reg     <= 3'd0;
            inval_reg   <= 1'b0;
            cr_reg      <= 1'b0;
            discard_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            bang_reg    <= bang_next;
            crc_reg     <= crc_next;
            snap_reg    <= snap_next;
            hex_reg     <= hex_next;
            cnt_reg     <= cnt_next;
            inval_reg   <= inval_next;
            cr_reg      <= cr_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// ----- rtl/dsmr_out_stage.sv -----
// ----------------------------------------------------------------------------
// DSMR result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dsmr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dsmr_pkg::result_t res,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dsmr_pkg::result_t m_res
);
    import dsmr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result may be written in the cycle the held one is taken.
    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// ----- rtl/dsmr_telegram_frame_checker_core.sv -----
// ----------------------------------------------------------------------------
// DSMR telegram frame checker
// Checks the start flag, framing and CRC-16/ARC of a P1 telegram byte stream.
// Path: an accepted byte is held in the input register, and its result is
// stored in the result register, which drives the master side.
// Throughput: one byte per cycle, held back only while the result register
// is full and not being taken.
// Reset clears both valid flags and all telegram state; no result is pending.
// ----------------------------------------------------------------------------
module dsmr_telegram_frame_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer
    input  logic        s_tuser,   // pre_verified
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] telegram_length, [31:16] received_crc,
                                   // [47:32] computed_crc
    output logic [1:0]  m_tuser    // [1:0] status
);
    import dsmr_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     proc_fire;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.data_byte     = s_tdata;
    assign s_item.end_of_buffer = s_tlast;
    assign s_item.pre_verified  = s_tuser;

    // A byte moves into the frame logic only when its result can be stored.
    assign proc_fire = item_valid && can_load;

    dsmr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .consume    (proc_fire),
        .item_valid (item_valid),
        .item       (item)
    );

    dsmr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (proc_fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    dsmr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (proc_fire && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {m_res.computed_crc, m_res.received_crc, m_res.telegram_length};
    assign m_tuser = m_res.status;

`ifndef ASSERT_OFF
    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(proc_fire))
        else $error("result appeared without a processed byte");

    a_no_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_NO_START) |-> (m_tdata == 48'h0))
        else $error("missing start flag result carries nonzero fields");

    a_incomplete_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_INCOMPLETE) |-> (m_tdata == 48'h0))
        else $error("incomplete result carries nonzero fields");

    a_no_fire_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !proc_fire)
        else $error("byte processed while result register is blocked");
`endif

endmodule
